FILE: rtl/isc_pkg.sv
// shared constants, types and control structs for the item support counter
`default_nettype none

package isc_pkg;

    // sizes of the counter store
    localparam int ITEM_SLOTS = 16384;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_BITS  = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;

    // fixed field widths
    localparam int ITEM_BITS      = 14;
    localparam int THRESHOLD_BITS = 16;
    localparam int TOTAL_BITS     = 15;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = THRESHOLD_BITS'(100);
    localparam logic [TOTAL_BITS-1:0]     TOTAL_MAX       = {TOTAL_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0]     COUNT_MAX       = {COUNT_BITS{1'b1}};
    localparam logic [ADDR_BITS-1:0]      LAST_SLOT       = ADDR_BITS'(ITEM_SLOTS - 1);

    typedef logic [ITEM_BITS-1:0]      item_t;
    typedef logic [THRESHOLD_BITS-1:0] threshold_t;
    typedef logic [TOTAL_BITS-1:0]     total_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [ADDR_BITS-1:0]      addr_t;

    // controller states, one-hot
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic update;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage : isc_pkg

`default_nettype wire

FILE: rtl/isc_if.sv
// channel interfaces for items, results and threshold writes
`default_nettype none

interface isc_item_if;
    logic                          valid;
    logic                          ready;
    logic [isc_pkg::ITEM_BITS-1:0] item_id;

    modport source (output valid, output item_id, input ready);
    modport sink   (input valid, input item_id, output ready);
endinterface : isc_item_if

interface isc_result_if;
    logic                           valid;
    logic                           ready;
    logic [isc_pkg::ITEM_BITS-1:0]  item_echo;
    logic                           newly_frequent;
    logic [isc_pkg::TOTAL_BITS-1:0] frequent_total;

    modport source (output valid, output item_echo, output newly_frequent,
                    output frequent_total, input ready);
    modport sink   (input valid, input item_echo, input newly_frequent,
                    input frequent_total, output ready);
endinterface : isc_result_if

interface isc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [isc_pkg::THRESHOLD_BITS-1:0] support_threshold;

    modport source (output valid, output support_threshold, input ready);
    modport sink   (input valid, input support_threshold, output ready);
endinterface : isc_cfg_if

`default_nettype wire

FILE: rtl/isc_ctrl.sv
// controller state machine: clearing sweep, item accept and counter update
`default_nettype none

module isc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    output isc_pkg::dp_cmd_t         cmd,
    input  wire isc_pkg::dp_status_t status
);
    import isc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands
    always_comb
    begin
        item_ready   = (state_reg == ST_IDLE);
        cmd.clear_en = (state_reg == ST_CLEAR);
        cmd.accept   = (state_reg == ST_IDLE) && item_valid;
        cmd.update   = (state_reg == ST_UPDATE) && status.out_free;
    end

endmodule : isc_ctrl

`default_nettype wire

FILE: rtl/isc_dp.sv
// datapath: counter store, threshold, frequent total and result register
`default_nettype none

module isc_dp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire isc_pkg::item_t         item_id,
    input  wire logic                   cfg_valid,
    input  wire isc_pkg::threshold_t    cfg_threshold,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output isc_pkg::item_t              item_echo,
    output logic                        newly_frequent,
    output isc_pkg::total_t             frequent_total,
    input  wire isc_pkg::dp_cmd_t       cmd,
    output isc_pkg::dp_status_t         status
);
    import isc_pkg::*;

    count_t     mem [ITEM_SLOTS];

    addr_t      clear_addr_reg;
    threshold_t threshold_reg;
    total_t     frequent_reg;
    total_t     frequent_next;
    item_t      item_reg;
    logic       in_store_reg;
    count_t     rd_data_reg;
    logic       out_valid_reg;
    item_t      echo_reg;
    logic       hit_reg;
    total_t     total_reg;

    count_t     count_inc;
    logic       bump;
    logic       hit;
    addr_t      in_addr;
    addr_t      cur_addr;

    assign in_addr  = ADDR_BITS'(item_id);
    assign cur_addr = ADDR_BITS'(item_reg);

    // counter update for the held beat
    always_comb
    begin
        count_inc = rd_data_reg + count_t'(1);
        bump      = in_store_reg
                    && (32'(rd_data_reg) < 32'(threshold_reg))
                    && (rd_data_reg != COUNT_MAX);
        hit       = bump && (32'(count_inc) == 32'(threshold_reg));
        if (hit && (frequent_reg != TOTAL_MAX))
        begin
            frequent_next = frequent_reg + total_t'(1);
        end
        else
        begin
            frequent_next = frequent_reg;
        end
    end

    // counter store: clearing sweep or update write, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            mem[clear_addr_reg] <= '0;
        end
        else if (cmd.update && bump)
        begin
            mem[cur_addr] <= count_inc;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[in_addr];
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg     <= item_id;
            in_store_reg <= (32'(item_id) < 32'(ITEM_SLOTS));
        end
    end

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clear_addr_reg <= clear_addr_reg + addr_t'(1);
        end
    end

    // threshold and frequent total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            frequent_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                threshold_reg <= cfg_threshold;
            end
            if (cmd.update)
            begin
                frequent_reg <= frequent_next;
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            echo_reg  <= item_reg;
            hit_reg   <= hit;
            total_reg <= frequent_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign item_echo         = echo_reg;
    assign newly_frequent    = hit_reg;
    assign frequent_total    = total_reg;
    assign status.clear_last = (clear_addr_reg == LAST_SLOT);
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule : isc_dp

`default_nettype wire

FILE: rtl/item_support_counter.sv
// top level of the item support counter
//
// Counts occurrences of item identifiers for frequent-itemset mining.
// items:   one item_id per beat; the result of each beat is one beat on results.
// results: item_echo, newly_frequent (this beat brought the count up to the
//          threshold) and frequent_total (items frequent so far, saturating).
// cfg:     writes support_threshold; always ready, write only while idle.
// Order:   an item beat is taken with its count read into a register; the
//          update step then writes the result register once it is free.
// Pacing:  the next item waits for the update step, set by the single-port
//          counter store's read-modify-write (read on accept, write on update).
// Reset: the threshold returns to 100 and the total to zero; then a clearing
//          sweep zeroes the counter store, one entry a cycle, up to its last
//          slot, while items.ready stays low.
// Stall: the result register holds while results.ready is low; the next item
//          is still taken and waits in the update step until the result
//          register frees up.
`default_nettype none

module item_support_counter (
    input  wire logic      clk,
    input  wire logic      rst_n,
    isc_item_if.sink       items,
    isc_result_if.source   results,
    isc_cfg_if.sink        cfg
);
    import isc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    // controller
    isc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (items.valid),
        .item_ready (items.ready),
        .cmd        (cmd),
        .status     (status)
    );

    // datapath
    isc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_id        (items.item_id),
        .cfg_valid      (cfg.valid),
        .cfg_threshold  (cfg.support_threshold),
        .out_ready      (results.ready),
        .out_valid      (results.valid),
        .item_echo      (results.item_echo),
        .newly_frequent (results.newly_frequent),
        .frequent_total (results.frequent_total),
        .cmd            (cmd),
        .status         (status)
    );

endmodule : item_support_counter

`default_nettype wire
